FILE: hw/rtl/mtd_pkg.sv
// Shared types and constants for the millisecond to time-digit converter.
// No dependencies; imported by every module of the block.
package mtd_pkg;

    // Digit code that leaves a display position dark.
    localparam logic [3:0] BLANK_CODE = 4'd10;

    // Reciprocal constants for exact division by a constant.
    localparam logic [31:0] RECIP_DIV10  = 32'hCCCC_CCCD;  // >> 35
    localparam logic [31:0] RECIP_DIV100 = 32'h51EB_851F;  // >> 37
    localparam logic [31:0] RECIP_DIV60  = 32'h8888_8889;  // >> 37
    localparam logic [10:0] RECIP_H100   = 11'd1311;       // >> 17, exact below 1200

    // Four two-digit fields, each held as a plain value below 100.
    typedef struct packed {
        logic       blank;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [6:0] centi;
    } t_fields;

    // Tens and ones of a value below 100: {tens, ones}.
    function automatic logic [7:0] split_digits(input logic [6:0] value);
        logic [17:0] prod;
        logic [3:0]  tens;
        logic [7:0]  tens10;
        logic [3:0]  ones;
        prod   = 18'(value) * 18'd205;
        tens   = prod[14:11];
        tens10 = 8'(tens) * 8'd10;
        ones   = 4'(value - tens10[6:0]);
        return {tens, ones};
    endfunction

endpackage

FILE: hw/rtl/mtd_divide.sv
// Six-stage divide pipeline splitting a millisecond count into time fields.
// Depends on mtd_pkg for the reciprocal constants and the field struct.
module mtd_divide
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_time_ms,
    input  logic        i_blank,
    output logic        o_valid,
    input  logic        i_ready,
    output t_fields     o_fields
);

    localparam int NSTAGE = 6;

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] adv;

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        adv[NSTAGE-1] = !r_v[NSTAGE-1] || i_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !r_v[i] || adv[i+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Stage 1: centisecond count, c = t / 10.
    logic [63:0] prod1;
    logic [28:0] r1_c;
    logic        r1_b;
    assign prod1 = 64'(i_time_ms) * 64'(RECIP_DIV10);

    // Stage 2: whole seconds, s = c / 100.
    logic [60:0] prod2;
    logic [22:0] r2_s;
    logic [6:0]  r2_c7;
    logic        r2_b;
    assign prod2 = 61'(r1_c) * 61'(RECIP_DIV100);

    // Stage 3: whole minutes, m = s / 60; centiseconds fall out of c - 100 s.
    logic [54:0] prod3;
    logic [13:0] s100;
    logic [16:0] r3_m;
    logic [5:0]  r3_s6;
    logic [6:0]  r3_centi;
    logic        r3_b;
    assign prod3 = 55'(r2_s) * 55'(RECIP_DIV60);
    assign s100  = 14'(r2_s[6:0]) * 14'd100;

    // Stage 4: whole hours, h = m / 60; seconds from s - 60 m.
    logic [48:0] prod4;
    logic [11:0] m60;
    logic [10:0] r4_h;
    logic [5:0]  r4_m6;
    logic [5:0]  r4_sec;
    logic [6:0]  r4_centi;
    logic        r4_b;
    assign prod4 = 49'(r3_m) * 49'(RECIP_DIV60);
    assign m60   = 12'(r3_m[5:0]) * 12'd60;

    // Stage 5: hundreds of hours; minutes from m - 60 h.
    logic [21:0] prod5;
    logic [11:0] h60;
    logic [3:0]  r5_hq;
    logic [6:0]  r5_h7;
    logic [5:0]  r5_min;
    logic [5:0]  r5_sec;
    logic [6:0]  r5_centi;
    logic        r5_b;
    assign prod5 = 22'(r4_h) * 22'(RECIP_H100);
    assign h60   = 12'(r4_h[5:0]) * 12'd60;

    // Stage 6: hours modulo 100.
    logic [10:0] hq100;
    t_fields     r6_f;
    assign hq100 = 11'(r5_hq) * 11'd100;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_c <= prod1[63:35];
            r1_b <= i_blank;
        end
        if (adv[1]) begin
            r2_s  <= prod2[59:37];
            r2_c7 <= r1_c[6:0];
            r2_b  <= r1_b;
        end
        if (adv[2]) begin
            r3_m     <= prod3[53:37];
            r3_s6    <= r2_s[5:0];
            r3_centi <= r2_c7 - s100[6:0];
            r3_b     <= r2_b;
        end
        if (adv[3]) begin
            r4_h     <= prod4[47:37];
            r4_m6    <= r3_m[5:0];
            r4_sec   <= r3_s6 - m60[5:0];
            r4_centi <= r3_centi;
            r4_b     <= r3_b;
        end
        if (adv[4]) begin
            r5_hq    <= prod5[20:17];
            r5_h7    <= r4_h[6:0];
            r5_min   <= r4_m6 - h60[5:0];
            r5_sec   <= r4_sec;
            r5_centi <= r4_centi;
            r5_b     <= r4_b;
        end
        if (adv[5]) begin
            r6_f.hour   <= r5_h7 - hq100[6:0];
            r6_f.minute <= 7'(r5_min);
            r6_f.second <= 7'(r5_sec);
            r6_f.centi  <= r5_centi;
            r6_f.blank  <= r5_b;
        end
    end

    assign o_fields = r6_f;

endmodule

FILE: hw/rtl/mtd_digits.sv
// Digit split, leading-zero blanking and output register of the converter.
// Depends on mtd_pkg for the field struct, the digit split and the blank code.
module mtd_digits
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_fields     i_fields,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digits
);

    logic        r_v;
    logic [31:0] r_digits;
    logic [31:0] n_digits;
    logic [7:0]  hd, md, sd, cd;
    logic        b0, b1, b2, b3;

    assign o_ready = !r_v || i_ready;

    // The blanking flag passes from hours down while every field so far is zero.
    always_comb begin
        hd = split_digits(i_fields.hour);
        md = split_digits(i_fields.minute);
        sd = split_digits(i_fields.second);
        cd = split_digits(i_fields.centi);
        b0 = i_fields.blank;
        b1 = b0 && (i_fields.hour == '0);
        b2 = b1 && (i_fields.minute == '0);
        b3 = b2 && (i_fields.second == '0);
        n_digits[3:0]   = (b0 && hd[7:4] == '0) ? BLANK_CODE : hd[7:4];
        n_digits[7:4]   = b1 ? BLANK_CODE : hd[3:0];
        n_digits[11:8]  = (b1 && md[7:4] == '0) ? BLANK_CODE : md[7:4];
        n_digits[15:12] = b2 ? BLANK_CODE : md[3:0];
        n_digits[19:16] = (b2 && sd[7:4] == '0) ? BLANK_CODE : sd[7:4];
        n_digits[23:20] = b3 ? BLANK_CODE : sd[3:0];
        n_digits[27:24] = (b3 && cd[7:4] == '0) ? BLANK_CODE : cd[7:4];
        n_digits[31:28] = (b3 && i_fields.centi == '0) ? BLANK_CODE : cd[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) begin
            r_digits <= n_digits;
        end
    end

    assign o_valid  = r_v;
    assign o_digits = r_digits;

endmodule

FILE: hw/rtl/ms_to_time_digits_top.sv
// Top level of the millisecond to time-digit converter.
// Depends on mtd_pkg, mtd_divide and mtd_digits.
//
// The block turns an elapsed time in milliseconds into eight decimal digits:
// hours modulo 100, minutes, seconds and centiseconds, two digits each.
// Input words arrive on the s_axis channel: tdata carries the 32-bit count and
// tuser the blank-leading flag. With that flag set, leading zero digits come
// out as the blank code 10; a ones digit goes dark only when its whole field
// is zero, and blanking moves on to the next field only while every earlier
// field was zero.
// Result words leave on the m_axis channel, one for each input word, in order.
// Each word passes through six divide stages, the first five built around
// one constant-reciprocal multiply each, then through the digit and
// blanking stage with its output register. A word can enter every cycle, so
// throughput is one word per cycle while the receiver takes words.
// When the receiver stalls, the pipeline fills up behind the output register
// and s_axis_tready falls only once no stage can move; nothing is lost or
// repeated. Synchronous reset empties every stage and drops both valid lines.
module ms_to_time_digits_top
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] time_ms
    input  logic        s_axis_tuser,  // [0] blank_leading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] hour_tens, [7:4] hour_ones, [11:8] minute_tens, [15:12] minute_ones,
    // [19:16] second_tens, [23:20] second_ones, [27:24] centi_tens,
    // [31:28] centi_ones
    output logic [31:0] m_axis_tdata
);

    logic    div_valid;
    logic    div_ready;
    t_fields div_fields;

    // Arithmetic part: successive divisions by 10, 100, 60, 60 and 100.
    mtd_divide u_divide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_time_ms (s_axis_tdata),
        .i_blank   (s_axis_tuser),
        .o_valid   (div_valid),
        .i_ready   (div_ready),
        .o_fields  (div_fields)
    );

    // Digit split and blanking, registered onto the output channel.
    mtd_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .o_ready  (div_ready),
        .i_fields (div_fields),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_digits (m_axis_tdata)
    );

endmodule

FILE: hw/rtl/mtd_checker.sv
// Port-level checks for the millisecond to time-digit converter.
// Depends on mtd_pkg for the blank code; bound to ms_to_time_digits_top.
module mtd_checker
    import mtd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // After reset the output channel is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // With the receiver ready every stage moves, so the input must be ready.
    a_flow_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // A blank hour, minute or second ones digit implies a blank hour tens digit.
    a_field_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[7:4] == BLANK_CODE
            || m_axis_tdata[15:12] == BLANK_CODE
            || m_axis_tdata[23:20] == BLANK_CODE)
        |-> m_axis_tdata[3:0] == BLANK_CODE)
        else $error("ones digit blank without tens digit blank");

    // A blank last digit means every digit is blank.
    a_all_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31:28] == BLANK_CODE
        |-> m_axis_tdata == {8{BLANK_CODE}})
        else $error("last digit blank but not all digits blank");

endmodule

bind ms_to_time_digits_top mtd_checker u_mtd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb.sv
// Self-checking bench for ms_to_time_digits_top: directed table, then random words.
// Depends on mtd_pkg for the blank digit code and on the RTL of the block alone.
`timescale 1ns / 1ps

module tb;
    import mtd_pkg::BLANK_CODE;

    localparam int NUM_DIRECTED   = 20;
    localparam int RANDOM_PER_RUN = 277;      // three runs of random words
    localparam int CYCLE_LIMIT    = 100000;
    localparam int MAX_REPORTS    = 10;

    // One row of the directed table. When is_typed is set the expected digits are
    // taken from the row, otherwise the digit predictor supplies them.
    typedef struct packed {
        logic [31:0] ms;
        logic        blank;
        logic        is_typed;
        logic [31:0] digits;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] time_ms
    logic        s_axis_tuser = 1'b0; // [0] blank_leading
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] hour_tens, [7:4] hour_ones, [11:8] minute_tens, [15:12] minute_ones,
    // [19:16] second_tens, [23:20] second_ones, [27:24] centi_tens,
    // [31:28] centi_ones
    logic [31:0] m_axis_tdata;

    stim_row_t   directed_rows [NUM_DIRECTED];
    logic [31:0] digits_due [$];      // expected result words, oldest first
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          blanked_results = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    string digit_names [8] = '{"hour_tens", "hour_ones", "minute_tens", "minute_ones",
                               "second_tens", "second_ones", "centi_tens", "centi_ones"};

    ms_to_time_digits_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Splits a millisecond count into the four two-digit fields and applies the
    // leading-zero blanking. The blanking flag only survives a field that is zero,
    // so the first non-zero field switches it off for everything to its right.
    function automatic logic [31:0] time_to_digits(input logic [31:0] ms,
                                                   input logic blank_in);
        int unsigned field [4];
        int unsigned tens;
        int unsigned ones;
        logic        dark;
        logic [31:0] word;
        field[0] = (ms / 32'd3600000) % 100;
        field[1] = (ms / 32'd60000) % 60;
        field[2] = (ms / 32'd1000) % 60;
        field[3] = (ms / 32'd10) % 100;
        dark = blank_in;
        word = '0;
        for (int k = 0; k < 4; k++) begin
            tens = field[k] / 10;
            ones = field[k] % 10;
            word[8*k +: 4]     = (dark && tens == 0) ? BLANK_CODE : 4'(tens);
            word[8*k + 4 +: 4] = (dark && field[k] == 0) ? BLANK_CODE : 4'(ones);
            dark = dark && (field[k] == 0);
        end
        return word;
    endfunction

    // Presents one word after a random gap and holds it until the block takes it.
    // The expectation is queued as the word goes up, so it is always in place
    // before any result of that word can appear, whatever the block's latency.
    task automatic send_word(input logic [31:0] ms, input logic blank,
                             input logic is_typed, input logic [31:0] digits);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ms;
        s_axis_tuser  <= blank;
        digits_due.push_back(is_typed ? digits : time_to_digits(ms, blank));
        words_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drops valid and holds off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
    endtask

    // Random counts, weighted towards values whose fields are often zero so that
    // the blanking chain is exercised to every depth, plus full-range noise.
    task automatic send_random_word();
        int unsigned pick;
        int unsigned ms;
        pick = $urandom_range(9);
        if (pick <= 2) begin
            ms = $urandom;
        end else if (pick <= 5) begin
            ms = ($urandom_range(2) == 0 ? 0 : $urandom_range(99)) * 3600000;
            ms += ($urandom_range(1) == 0 ? 0 : $urandom_range(59)) * 60000;
            ms += ($urandom_range(1) == 0 ? 0 : $urandom_range(59)) * 1000;
            ms += ($urandom_range(1) == 0 ? 0 : $urandom_range(99)) * 10;
            ms += $urandom_range(9);
            if ($urandom_range(4) == 0)
                ms += $urandom_range(10) * 360000000;   // hours past 99 wrap
        end else if (pick <= 7) begin
            ms = $urandom_range(120000);
        end else if (pick == 8) begin
            // Just either side of a unit boundary.
            case ($urandom_range(3))
                0: ms = $urandom_range(1, 400000) * 10;
                1: ms = $urandom_range(1, 4000000) * 1000;
                2: ms = $urandom_range(1, 70000) * 60000;
                default: ms = $urandom_range(1, 1190) * 3600000;
            endcase
            ms = ms + $urandom_range(2) - 1;
        end else begin
            ms = 32'hFFFF_FFFF - $urandom_range(5000000);
        end
        send_word(ms, 1'($urandom_range(1)), 1'b0, '0);
    endtask

    // The receiver decides afresh at every falling edge whether to take a word.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: each word taken is compared digit by digit with the oldest
    // expectation.
    always @(posedge i_clk) begin : check_results
        logic [31:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            for (int k = 0; k < 8; k++)
                if (m_axis_tdata[4*k +: 4] == BLANK_CODE) begin
                    blanked_results++;
                    break;
                end
            if (digits_due.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result %h arrived with nothing expected", $realtime,
                             m_axis_tdata);
                mismatches++;
            end else begin
                want = digits_due.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (m_axis_tdata[4*k +: 4] !== want[4*k +: 4]) begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: %s expected %0d, got %0d (word %h, expected %h)",
                                     $realtime, digit_names[k], want[4*k +: 4],
                                     m_axis_tdata[4*k +: 4], m_axis_tdata, want);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, digits_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        // Typed rows are the ones that can be read straight off the definition:
        // zero with and without blanking, the all-ones count, a count under one
        // centisecond, the first centisecond, the last count before a second, the
        // first second, and exactly 100 hours, which wraps to all-zero fields.
        directed_rows = '{
            {32'd0,          1'b0, 1'b1, 32'h0000_0000},
            {32'd0,          1'b1, 1'b1, 32'hAAAA_AAAA},
            {32'hFFFF_FFFF,  1'b0, 1'b1, 32'h9274_2039},
            {32'hFFFF_FFFF,  1'b1, 1'b1, 32'h9274_2039},
            {32'd9,          1'b1, 1'b1, 32'hAAAA_AAAA},
            {32'd5,          1'b0, 1'b1, 32'h0000_0000},
            {32'd10,         1'b1, 1'b1, 32'h1AAA_AAAA},
            {32'd999,        1'b1, 1'b1, 32'h99AA_AAAA},
            {32'd1000,       1'b1, 1'b1, 32'h001A_AAAA},
            {32'd360000000,  1'b1, 1'b1, 32'hAAAA_AAAA},
            {32'd360000000,  1'b0, 1'b1, 32'h0000_0000},
            {32'd600,        1'b1, 1'b0, 32'h0},
            {32'd59999,      1'b1, 1'b0, 32'h0},
            {32'd60000,      1'b1, 1'b0, 32'h0},
            {32'd600000,     1'b1, 1'b0, 32'h0},
            {32'd3599999,    1'b1, 1'b0, 32'h0},
            {32'd3600000,    1'b1, 1'b0, 32'h0},
            {32'd36000000,   1'b1, 1'b0, 32'h0},
            {32'h8000_0000,  1'b0, 1'b0, 32'h0},
            {32'h5555_5555,  1'b1, 1'b0, 32'h0}
        };

        // Receiver-starved handshake for the directed part and first random run.
        send_idle_pct = 15;
        recv_idle_pct = 79;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_word(directed_rows[r].ms, directed_rows[r].blank,
                      directed_rows[r].is_typed, directed_rows[r].digits);
        // Let the pipeline run completely dry once before the random part.
        drain_results();

        for (int run = 0; run < 3; run++) begin
            case (run)
                0: begin send_idle_pct = 15; recv_idle_pct = 79; end
                1: begin send_idle_pct = 79; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_RUN; n++)
                send_random_word();
            drain_results();
        end

        // Wait beyond the block's latency for stray results.
        repeat (16) @(posedge i_clk);

        $display("Converted %0d words (%0d from the table) under three handshake mixes.",
                 words_sent, NUM_DIRECTED);
        $display("Checked %0d results, %0d with dark digits; %0d digit errors.",
                 results_seen, blanked_results, mismatches);
        if (mismatches == 0 && digits_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_divide.sv
hw/rtl/mtd_digits.sv
hw/rtl/ms_to_time_digits_top.sv
hw/rtl/mtd_checker.sv
verif/tb.sv
